/* rtl/core/plfr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Playfair digraph cipher package
// Shared types and constants: letter and key table types, the pair record
// that travels from the pairing front end to the substitution back end,
// configuration register indexes and queue sizing.
// ----------------------------------------------------------------------------
package plfr_pkg;

    // Character and letter encoding.
    localparam int CHAR_W      = 8;
    localparam int LETTER_W    = 5;
    localparam int TABLE_SIZE  = 32;
    localparam int POS_W       = 5;
    localparam int GROUP_SIZE  = 8;

    // Filler letter (byte 0xFA) and the upper byte bits of every output letter.
    localparam logic [LETTER_W-1:0]        FILLER_INDEX = 5'd26;
    localparam logic [CHAR_W-LETTER_W-1:0] LETTER_BASE  = 3'b111;
    // Upper bits of any byte 0xC0 and above: upper or lower case letter.
    localparam logic [1:0]                 LETTER_TAG   = 2'b11;

    // Configuration port.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 40;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_DECRYPT_MODE  = 3'd0,
        REG_TABLE_GROUP_0 = 3'd1,
        REG_TABLE_GROUP_1 = 3'd2,
        REG_TABLE_GROUP_2 = 3'd3,
        REG_TABLE_GROUP_3 = 3'd4
    } cfg_reg_t;

    // Pair queue sizing.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCOUNT_W    = 3;

    typedef logic [LETTER_W-1:0] letter_t;
    typedef letter_t [TABLE_SIZE-1:0] key_table_t;

    // One letter pair waiting for substitution.
    typedef struct packed {
        letter_t first;
        letter_t second;
        logic    last;
    } pair_t;

    // Up to two pairs written into the queue in one cycle.
    typedef struct packed {
        logic  push0;
        logic  push1;
        pair_t entry0;
        pair_t entry1;
    } push_t;

endpackage

/* rtl/core/plfr_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Playfair front end
// Accepts characters, folds case, drops non-letters and forms letter pairs,
// inserting the filler letter for doubled letters and at the end of a line.
// ----------------------------------------------------------------------------
module plfr_front
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [plfr_pkg::CHAR_W-1:0] in_char,
    input  logic                      end_of_line,
    input  logic                      space_ok,
    output plfr_pkg::push_t           push
);

    plfr_pkg::letter_t held_letter_reg;
    plfr_pkg::letter_t held_letter_next;
    logic              held_valid_reg;
    logic              held_valid_next;
    logic              accept;
    logic              is_letter;
    plfr_pkg::letter_t letter;

    // The queue must have room for two pairs before a character is taken.
    assign in_ready  = space_ok;
    assign accept    = in_valid && in_ready;
    assign is_letter = (in_char[plfr_pkg::CHAR_W-1 -: 2] == plfr_pkg::LETTER_TAG);
    assign letter    = in_char[plfr_pkg::LETTER_W-1:0];

    // Pairing decisions for one accepted character.
    always_comb
    begin
        push             = '0;
        held_letter_next = held_letter_reg;
        held_valid_next  = held_valid_reg;
        if (accept)
        begin
            if (is_letter)
            begin
                if (!held_valid_reg)
                begin
                    held_letter_next = letter;
                    held_valid_next  = 1'b1;
                end
                else if (held_letter_reg == letter)
                begin
                    // Doubled letter: pad the held one, the new one stays held.
                    push.push0  = 1'b1;
                    push.entry0 = plfr_pkg::pair_t'{first: held_letter_reg,
                                                    second: plfr_pkg::FILLER_INDEX,
                                                    last: 1'b1};
                end
                else
                begin
                    push.push0       = 1'b1;
                    push.entry0      = plfr_pkg::pair_t'{first: held_letter_reg,
                                                         second: letter,
                                                         last: 1'b1};
                    held_letter_next = '0;
                    held_valid_next  = 1'b0;
                end
            end
            // End of line flushes a letter still held with the filler.
            if (end_of_line && held_valid_next)
            begin
                if (push.push0)
                begin
                    push.entry0.last = 1'b0;
                    push.push1       = 1'b1;
                    push.entry1      = plfr_pkg::pair_t'{first: held_letter_next,
                                                         second: plfr_pkg::FILLER_INDEX,
                                                         last: 1'b1};
                end
                else
                begin
                    push.push0  = 1'b1;
                    push.entry0 = plfr_pkg::pair_t'{first: held_letter_next,
                                                    second: plfr_pkg::FILLER_INDEX,
                                                    last: 1'b1};
                end
                held_letter_next = '0;
                held_valid_next  = 1'b0;
            end
        end
    end

    // Held letter state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_letter_reg <= '0;
            held_valid_reg  <= 1'b0;
        end
        else
        begin
            held_letter_reg <= held_letter_next;
            held_valid_reg  <= held_valid_next;
        end
    end

endmodule

/* rtl/core/plfr_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Playfair pair queue
// Short queue between front and back end: up to two writes and one read in
// each cycle, so either side can stall briefly without holding up the other.
// ----------------------------------------------------------------------------
module plfr_queue
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  plfr_pkg::push_t               push,
    input  logic                          pop,
    output plfr_pkg::pair_t               head,
    output logic                          not_empty,
    output logic                          space_ok,
    output logic [plfr_pkg::QCOUNT_W-1:0] count
);

    plfr_pkg::pair_t                 entry_reg [plfr_pkg::QUEUE_DEPTH];
    logic [plfr_pkg::QPTR_W-1:0]     head_reg;
    logic [plfr_pkg::QPTR_W-1:0]     head_next;
    logic [plfr_pkg::QPTR_W-1:0]     tail_reg;
    logic [plfr_pkg::QPTR_W-1:0]     tail_next;
    logic [plfr_pkg::QPTR_W-1:0]     tail_plus1;
    logic [plfr_pkg::QCOUNT_W-1:0]   count_reg;
    logic [plfr_pkg::QCOUNT_W-1:0]   count_next;
    logic [plfr_pkg::QCOUNT_W-1:0]   push_count;

    assign tail_plus1 = tail_reg + 1'b1;
    assign push_count = plfr_pkg::QCOUNT_W'(push.push0) + plfr_pkg::QCOUNT_W'(push.push1);
    assign tail_next  = tail_reg + plfr_pkg::QPTR_W'(push_count);
    assign head_next  = head_reg + plfr_pkg::QPTR_W'(pop);
    assign count_next = count_reg + push_count - plfr_pkg::QCOUNT_W'(pop);

    assign head      = entry_reg[head_reg];
    assign not_empty = (count_reg != '0);
    assign space_ok  = (count_reg <= plfr_pkg::QCOUNT_W'(plfr_pkg::QUEUE_DEPTH - 2));
    assign count     = count_reg;

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push.push0)
        begin
            entry_reg[tail_reg] <= push.entry0;
        end
        if (push.push1)
        begin
            entry_reg[tail_plus1] <= push.entry1;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

endmodule

/* rtl/core/plfr_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Playfair back end
// Three-stage substitution pipeline: locate both letters in the key table,
// apply the row, column or rectangle rule, then read the table into the
// output register. The whole pipeline advances when the output can move.
// ----------------------------------------------------------------------------
module plfr_back
#(
    parameter int ROWS_COUNT    = 8,
    parameter int COLUMNS_COUNT = 4
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_valid,
    input  plfr_pkg::pair_t             q_head,
    output logic                        q_pop,
    input  logic                        decrypt_mode,
    input  plfr_pkg::key_table_t        key_table,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [plfr_pkg::CHAR_W-1:0] out_first,
    output logic [plfr_pkg::CHAR_W-1:0] out_second,
    output logic                        last_of_run
);

    localparam int CELLS = ROWS_COUNT * COLUMNS_COUNT;
    localparam int USED  = (CELLS > plfr_pkg::TABLE_SIZE) ? plfr_pkg::TABLE_SIZE : CELLS;
    localparam int RW    = (ROWS_COUNT > 1) ? $clog2(ROWS_COUNT) : 1;
    localparam int CW    = (COLUMNS_COUNT > 1) ? $clog2(COLUMNS_COUNT) : 1;
    localparam int PW    = $clog2(CELLS + plfr_pkg::TABLE_SIZE);

    logic                           advance;

    logic                           s1_valid_reg;
    logic [plfr_pkg::POS_W-1:0]     s1_pos_a_reg;
    logic [plfr_pkg::POS_W-1:0]     s1_pos_b_reg;
    logic                           s1_last_reg;

    logic                           s2_valid_reg;
    logic [plfr_pkg::POS_W-1:0]     s2_pos_a_reg;
    logic [plfr_pkg::POS_W-1:0]     s2_pos_b_reg;
    logic                           s2_last_reg;

    logic                           out_valid_reg;
    logic [plfr_pkg::CHAR_W-1:0]    out_first_reg;
    logic [plfr_pkg::CHAR_W-1:0]    out_second_reg;
    logic                           out_last_reg;

    logic [RW-1:0]                  row_a;
    logic [RW-1:0]                  row_b;
    logic [CW-1:0]                  col_a;
    logic [CW-1:0]                  col_b;
    logic [RW-1:0]                  new_row_a;
    logic [RW-1:0]                  new_row_b;
    logic [CW-1:0]                  new_col_a;
    logic [CW-1:0]                  new_col_b;
    logic [PW-1:0]                  cell_a;
    logic [PW-1:0]                  cell_b;

    // Lowest table position holding the letter; position 0 when absent.
    function automatic logic [plfr_pkg::POS_W-1:0] find_pos(
        input plfr_pkg::key_table_t tbl,
        input plfr_pkg::letter_t    letter
    );
        logic [plfr_pkg::POS_W-1:0] pos;
        pos = '0;
        for (int p = USED - 1; p >= 0; p--)
        begin
            if (tbl[p] == letter)
            begin
                pos = plfr_pkg::POS_W'(p);
            end
        end
        return pos;
    endfunction

    // Row of a table position, looked up from a constant table.
    function automatic logic [RW-1:0] row_of(input logic [plfr_pkg::POS_W-1:0] pos);
        logic [RW-1:0] r;
        r = '0;
        for (int p = 0; p < plfr_pkg::TABLE_SIZE; p++)
        begin
            if (pos == plfr_pkg::POS_W'(p))
            begin
                r = RW'(p / COLUMNS_COUNT);
            end
        end
        return r;
    endfunction

    // Column of a table position, looked up from a constant table.
    function automatic logic [CW-1:0] col_of(input logic [plfr_pkg::POS_W-1:0] pos);
        logic [CW-1:0] c;
        c = '0;
        for (int p = 0; p < plfr_pkg::TABLE_SIZE; p++)
        begin
            if (pos == plfr_pkg::POS_W'(p))
            begin
                c = CW'(p % COLUMNS_COUNT);
            end
        end
        return c;
    endfunction

    // One column step with wrap, right or left.
    function automatic logic [CW-1:0] step_col(input logic [CW-1:0] c, input logic dec);
        logic [CW-1:0] r;
        if (dec)
        begin
            r = (c == '0) ? CW'(COLUMNS_COUNT - 1) : c - 1'b1;
        end
        else
        begin
            r = (c == CW'(COLUMNS_COUNT - 1)) ? '0 : c + 1'b1;
        end
        return r;
    endfunction

    // One row step with wrap, down or up.
    function automatic logic [RW-1:0] step_row(input logic [RW-1:0] rw, input logic dec);
        logic [RW-1:0] r;
        if (dec)
        begin
            r = (rw == '0) ? RW'(ROWS_COUNT - 1) : rw - 1'b1;
        end
        else
        begin
            r = (rw == RW'(ROWS_COUNT - 1)) ? '0 : rw + 1'b1;
        end
        return r;
    endfunction

    assign advance = !out_valid_reg || out_ready;
    assign q_pop   = advance && q_valid;

    // Stage two: split positions into row and column and apply the rule.
    always_comb
    begin
        row_a     = row_of(s1_pos_a_reg);
        col_a     = col_of(s1_pos_a_reg);
        row_b     = row_of(s1_pos_b_reg);
        col_b     = col_of(s1_pos_b_reg);
        new_row_a = row_a;
        new_row_b = row_b;
        new_col_a = col_a;
        new_col_b = col_b;
        if (row_a == row_b)
        begin
            new_col_a = step_col(col_a, decrypt_mode);
            new_col_b = step_col(col_b, decrypt_mode);
        end
        else if (col_a == col_b)
        begin
            new_row_a = step_row(row_a, decrypt_mode);
            new_row_b = step_row(row_b, decrypt_mode);
        end
        else
        begin
            new_col_a = col_b;
            new_col_b = col_a;
        end
        cell_a = PW'(new_row_a) * PW'(COLUMNS_COUNT) + PW'(new_col_a);
        cell_b = PW'(new_row_b) * PW'(COLUMNS_COUNT) + PW'(new_col_b);
    end

    // Valid bits of the pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= q_valid;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    // Pipeline payload; positions past the table wrap round it.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_pos_a_reg   <= find_pos(key_table, q_head.first);
            s1_pos_b_reg   <= find_pos(key_table, q_head.second);
            s1_last_reg    <= q_head.last;
            s2_pos_a_reg   <= cell_a[plfr_pkg::POS_W-1:0];
            s2_pos_b_reg   <= cell_b[plfr_pkg::POS_W-1:0];
            s2_last_reg    <= s1_last_reg;
            out_first_reg  <= {plfr_pkg::LETTER_BASE, key_table[s2_pos_a_reg]};
            out_second_reg <= {plfr_pkg::LETTER_BASE, key_table[s2_pos_b_reg]};
            out_last_reg   <= s2_last_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_first   = out_first_reg;
    assign out_second  = out_second_reg;
    assign last_of_run = out_last_reg;

endmodule

/* rtl/core/playfair_digraph_cipher.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Playfair digraph cipher
// Streams single-byte Cyrillic text through a configurable Playfair table,
// one character in and one letter pair out per cycle when nothing stalls.
// ----------------------------------------------------------------------------
// Usage:
// - Input channel (in_valid/in_ready) takes one character and its end_of_line
//   flag per transaction. Letters are case-folded and paired; other bytes are
//   dropped. Doubled letters and a letter left at end of line get the filler.
// - Output channel (out_valid/out_ready) gives one pair per transaction;
//   last_of_run marks the final pair caused by one character.
// - Configuration: cfg_we writes cfg_wdata into the register at cfg_index
//   (0 mode, 1 to 4 table groups); write only while the block is idle.
// - Path: a closed pair passes the pair queue, then the substitution stages
//   and the output register.
// - Throughput: one character per cycle while the queue has room, and one
//   pair per cycle from the back end while the receiver takes it.
// - Input ready needs room for two pairs in the four-entry pair queue.
// - When the receiver stalls, the output register holds and the pipeline
//   stops; input ready falls once the queue holds three or four pairs.
// - Reset clears the held letter, the queue and the pipeline, sets encrypt
//   mode and loads the identity table.
// ----------------------------------------------------------------------------
module playfair_digraph_cipher
#(
    parameter int ROWS_COUNT    = 8,
    parameter int COLUMNS_COUNT = 4
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [plfr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [plfr_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [plfr_pkg::CHAR_W-1:0]      in_char,
    input  logic                             end_of_line,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [plfr_pkg::CHAR_W-1:0]      out_first,
    output logic [plfr_pkg::CHAR_W-1:0]      out_second,
    output logic                             last_of_run
);

    logic                          decrypt_mode_reg;
    plfr_pkg::key_table_t          table_reg;
    plfr_pkg::push_t               push;
    plfr_pkg::pair_t               q_head;
    logic                          q_valid;
    logic                          q_pop;
    logic                          space_ok;
    logic [plfr_pkg::QCOUNT_W-1:0] q_count;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decrypt_mode_reg <= 1'b0;
            for (int p = 0; p < plfr_pkg::TABLE_SIZE; p++)
            begin
                table_reg[p] <= plfr_pkg::LETTER_W'(p);
            end
        end
        else if (cfg_we)
        begin
            case (plfr_pkg::cfg_reg_t'(cfg_index))
                plfr_pkg::REG_DECRYPT_MODE:  decrypt_mode_reg <= cfg_wdata[0];
                plfr_pkg::REG_TABLE_GROUP_0: table_reg[7:0]   <= cfg_wdata;
                plfr_pkg::REG_TABLE_GROUP_1: table_reg[15:8]  <= cfg_wdata;
                plfr_pkg::REG_TABLE_GROUP_2: table_reg[23:16] <= cfg_wdata;
                plfr_pkg::REG_TABLE_GROUP_3: table_reg[31:24] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Pairing front end.
    plfr_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_char     (in_char),
        .end_of_line (end_of_line),
        .space_ok    (space_ok),
        .push        (push)
    );

    // Pair queue.
    plfr_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (q_pop),
        .head      (q_head),
        .not_empty (q_valid),
        .space_ok  (space_ok),
        .count     (q_count)
    );

    // Substitution back end.
    plfr_back
    #(
        .ROWS_COUNT    (ROWS_COUNT),
        .COLUMNS_COUNT (COLUMNS_COUNT)
    )
    u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .decrypt_mode (decrypt_mode_reg),
        .key_table    (table_reg),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_first    (out_first),
        .out_second   (out_second),
        .last_of_run  (last_of_run)
    );

`ifndef SYNTHESIS
    // A second pair is only ever written behind a first one, and only the
    // second carries the end-of-run mark.
    a_push_order: assert property (@(posedge clk) disable iff (!rst_n)
        push.push1 |-> (push.push0 && !push.entry0.last && push.entry1.last))
        else $error("second pair pushed without a proper first pair");

    // The queue never holds more pairs than it has entries.
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= plfr_pkg::QCOUNT_W'(plfr_pkg::QUEUE_DEPTH))
        else $error("pair queue overflow");

    // A non-letter that does not close a line produces no pair.
    a_drop_nonletter: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (in_char[7:6] != plfr_pkg::LETTER_TAG) && !end_of_line)
        |-> !push.push0)
        else $error("pair produced by a dropped character");

    // The back end never reads from an empty queue.
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (q_count != '0))
        else $error("pop from empty pair queue");
`endif

endmodule

/* tb/sv/cipher_check_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Playfair digraph cipher checking package
// Holds the letter pair predictor and the queue of pairs still owed by the
// block. The predictor tracks its own copy of the mode, the key table and the
// letter that waits for a partner.
// ----------------------------------------------------------------------------
package cipher_check_pkg;

    // Key table geometry used by both the block and the predictor.
    localparam int KEY_ROWS    = 8;
    localparam int KEY_COLUMNS = 4;
    // Table positions searched for a letter.
    localparam int KEY_USED    = (KEY_ROWS * KEY_COLUMNS > plfr_pkg::TABLE_SIZE) ?
                                 plfr_pkg::TABLE_SIZE : KEY_ROWS * KEY_COLUMNS;

    // One substituted pair as it leaves the block.
    typedef struct packed {
        logic [plfr_pkg::CHAR_W-1:0] first;
        logic [plfr_pkg::CHAR_W-1:0] second;
        logic                        last;
    } cipher_pair_t;

    class digraph_scoreboard;

        bit                decrypt;
        plfr_pkg::letter_t key_table [plfr_pkg::TABLE_SIZE];
        plfr_pkg::letter_t held;
        bit                held_ok;
        cipher_pair_t      expected_pairs [$];
        int unsigned       mismatches;

        function new();
            decrypt = 1'b0;
            for (int p = 0; p < plfr_pkg::TABLE_SIZE; p++)
            begin
                key_table[p] = plfr_pkg::letter_t'(p);
            end
            held       = '0;
            held_ok    = 1'b0;
            mismatches = 0;
        endfunction

        // Prints one line per mismatch and keeps the count.
        task report(string what);
            mismatches++;
            $display("MISMATCH at %0t: %s", $realtime, what);
        endtask

        // Mirrors a register write; indexes past the table groups are ignored.
        function void set_register(logic [plfr_pkg::CFG_INDEX_W-1:0] idx,
                                   logic [plfr_pkg::CFG_DATA_W-1:0] v);
            int g;
            case (idx)
                plfr_pkg::REG_DECRYPT_MODE:
                begin
                    decrypt = v[0];
                end
                plfr_pkg::REG_TABLE_GROUP_0, plfr_pkg::REG_TABLE_GROUP_1,
                plfr_pkg::REG_TABLE_GROUP_2, plfr_pkg::REG_TABLE_GROUP_3:
                begin
                    g = int'(idx) - int'(plfr_pkg::REG_TABLE_GROUP_0);
                    for (int k = 0; k < plfr_pkg::GROUP_SIZE; k++)
                    begin
                        key_table[plfr_pkg::GROUP_SIZE * g + k] =
                            v[plfr_pkg::LETTER_W * k +: plfr_pkg::LETTER_W];
                    end
                end
                default:
                begin
                end
            endcase
        endfunction

        // Lowest position holding the letter; a missing letter sits at position 0.
        function int position_of(plfr_pkg::letter_t l);
            for (int p = 0; p < KEY_USED; p++)
            begin
                if (key_table[p] == l)
                    return p;
            end
            return 0;
        endfunction

        // Playfair substitution of one letter pair.
        function cipher_pair_t encipher(plfr_pkg::letter_t a, plfr_pkg::letter_t b);
            int                pa;
            int                pb;
            int                ra;
            int                ca;
            int                rb;
            int                cb;
            plfr_pkg::letter_t x;
            plfr_pkg::letter_t y;
            cipher_pair_t      r;
            pa = position_of(a);
            pb = position_of(b);
            ra = pa / KEY_COLUMNS;
            ca = pa % KEY_COLUMNS;
            rb = pb / KEY_COLUMNS;
            cb = pb % KEY_COLUMNS;
            if (ra == rb)
            begin
                ca = decrypt ? (ca + KEY_COLUMNS - 1) % KEY_COLUMNS : (ca + 1) % KEY_COLUMNS;
                cb = decrypt ? (cb + KEY_COLUMNS - 1) % KEY_COLUMNS : (cb + 1) % KEY_COLUMNS;
                x  = key_table[(ra * KEY_COLUMNS + ca) % plfr_pkg::TABLE_SIZE];
                y  = key_table[(rb * KEY_COLUMNS + cb) % plfr_pkg::TABLE_SIZE];
            end
            else if (ca == cb)
            begin
                ra = decrypt ? (ra + KEY_ROWS - 1) % KEY_ROWS : (ra + 1) % KEY_ROWS;
                rb = decrypt ? (rb + KEY_ROWS - 1) % KEY_ROWS : (rb + 1) % KEY_ROWS;
                x  = key_table[(ra * KEY_COLUMNS + ca) % plfr_pkg::TABLE_SIZE];
                y  = key_table[(rb * KEY_COLUMNS + cb) % plfr_pkg::TABLE_SIZE];
            end
            else
            begin
                x = key_table[(ra * KEY_COLUMNS + cb) % plfr_pkg::TABLE_SIZE];
                y = key_table[(rb * KEY_COLUMNS + ca) % plfr_pkg::TABLE_SIZE];
            end
            r.first  = {plfr_pkg::LETTER_BASE, x};
            r.second = {plfr_pkg::LETTER_BASE, y};
            r.last   = 1'b0;
            return r;
        endfunction

        // Pairs up one accepted character and queues the pairs it closes.
        function void note_char(logic [plfr_pkg::CHAR_W-1:0] c, logic eol);
            cipher_pair_t      made [2];
            int                n;
            plfr_pkg::letter_t l;
            n = 0;
            if (c[plfr_pkg::CHAR_W-1 -: 2] == plfr_pkg::LETTER_TAG)
            begin
                l = c[plfr_pkg::LETTER_W-1:0];
                if (!held_ok)
                begin
                    held    = l;
                    held_ok = 1'b1;
                end
                else if (held == l)
                begin
                    // Doubled letter: filler closes the pair, the letter stays held.
                    made[n] = encipher(held, plfr_pkg::FILLER_INDEX);
                    n++;
                end
                else
                begin
                    made[n] = encipher(held, l);
                    n++;
                    held    = '0;
                    held_ok = 1'b0;
                end
            end
            // End of line flushes a held letter, whatever the character was.
            if (eol && held_ok)
            begin
                made[n] = encipher(held, plfr_pkg::FILLER_INDEX);
                n++;
                held    = '0;
                held_ok = 1'b0;
            end
            for (int i = 0; i < n; i++)
            begin
                made[i].last = (i == n - 1);
                expected_pairs.insert(expected_pairs.size(), made[i]);
            end
        endfunction

        // Compares one accepted pair with the oldest one owed.
        task check_pair(logic [plfr_pkg::CHAR_W-1:0] first,
                        logic [plfr_pkg::CHAR_W-1:0] second, logic last);
            cipher_pair_t want;
            if (expected_pairs.size() == 0)
            begin
                report($sformatf("pair %h %h last %b with nothing expected", first, second, last));
                return;
            end
            want = expected_pairs.pop_front();
            if (first !== want.first)
                report($sformatf("out_first %h, expected %h", first, want.first));
            if (second !== want.second)
                report($sformatf("out_second %h, expected %h", second, want.second));
            if (last !== want.last)
                report($sformatf("last_of_run %b, expected %b", last, want.last));
        endtask

        function int pending();
            return expected_pairs.size();
        endfunction

    endclass

endpackage

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Playfair digraph cipher testbench
// Sends a short directed text and then random well-formed Cyrillic text with
// spaces, stray bytes and line ends through the cipher under a series of key
// tables and modes, with random gaps and stalls on both channels. Every pair
// is checked against a predictor of the pairing and the substitution.
// ----------------------------------------------------------------------------
module testbench;

    localparam int PHASE_COUNT    = 10;
    localparam int PHASE_ITEMS    = 195;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 8;
    localparam int STALL_LIMIT    = 4000;
    localparam int PRESSURE_PHASE = 2;
    localparam int UNUSED_PHASE   = 8;

    localparam logic [plfr_pkg::CHAR_W-1:0]      SPACE_CHAR = 8'h20;
    localparam logic [plfr_pkg::CHAR_W-1:0]      UPPER_BASE = 8'hC0;
    localparam logic [plfr_pkg::CHAR_W-1:0]      LOWER_BASE = 8'hE0;
    localparam logic [plfr_pkg::CFG_INDEX_W-1:0] FIRST_UNUSED_REG =
        plfr_pkg::CFG_INDEX_W'(plfr_pkg::REG_TABLE_GROUP_3) + 1'b1;

    // Key table shapes applied per phase.
    typedef enum int {
        KEY_IDENTITY,
        KEY_SHUFFLED,
        KEY_ALL_ZERO,
        KEY_ALL_ONES,
        KEY_ARBITRARY,
        KEY_DUPLICATE
    } key_shape_t;

    logic                             clk   = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             cfg_we;
    logic [plfr_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [plfr_pkg::CFG_DATA_W-1:0]  cfg_wdata;
    logic                             in_valid;
    logic                             in_ready;
    logic [plfr_pkg::CHAR_W-1:0]      in_char;
    logic                             end_of_line;
    logic                             out_valid;
    logic                             out_ready;
    logic [plfr_pkg::CHAR_W-1:0]      out_first;
    logic [plfr_pkg::CHAR_W-1:0]      out_second;
    logic                             last_of_run;

    cipher_check_pkg::digraph_scoreboard sb = new();

    bit                idle_on  = 1'b1;
    bit                hold_req = 1'b0;
    plfr_pkg::letter_t last_letter = '0;
    plfr_pkg::letter_t staged_table [plfr_pkg::TABLE_SIZE];
    int unsigned       quiet_cycles = 0;

    playfair_digraph_cipher
    #(
        .ROWS_COUNT    (cipher_check_pkg::KEY_ROWS),
        .COLUMNS_COUNT (cipher_check_pkg::KEY_COLUMNS)
    )
    dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_char     (in_char),
        .end_of_line (end_of_line),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_first   (out_first),
        .out_second  (out_second),
        .last_of_run (last_of_run)
    );

    // Clock, 2 ns period.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        int k;
        k = $urandom_range(0, 99);
        if (k < 80)
            return $urandom_range(1, 3);
        else if (k < 98)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // Record every transaction on both channels.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_char(in_char, end_of_line);
            if (out_valid && out_ready)
                sb.check_pair(out_first, out_second, last_of_run);
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == STALL_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off on request.
    initial
    begin
        int stall_left;
        stall_left = 0;
        out_ready  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_ready <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 3) == 0)
            begin
                stall_left = gap_len() - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Offers one character and waits for its transaction; valid stays high.
    task automatic send_char(input logic [plfr_pkg::CHAR_W-1:0] c, input logic eol);
        int gap;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? gap_len() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        in_char     <= c;
        end_of_line <= eol;
        do
            @(posedge clk);
        while (!(in_valid && in_ready));
    endtask

    // Drops valid and waits until every owed pair has come out.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register write; cfg_we is lowered by the caller after the last one.
    task automatic write_reg(input logic [plfr_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [plfr_pkg::CFG_DATA_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge clk);
        sb.set_register(idx, v);
    endtask

    function automatic logic [plfr_pkg::CFG_DATA_W-1:0] random_word();
        return {8'($urandom), 32'($urandom)};
    endfunction

    // Builds a key table of the given shape and writes mode and all groups.
    task automatic load_key(input key_shape_t shape, input logic mode, input bit poke_unused);
        logic [plfr_pkg::CFG_DATA_W-1:0] grp;
        plfr_pkg::letter_t               t;
        int                              j;
        for (int p = 0; p < plfr_pkg::TABLE_SIZE; p++)
        begin
            staged_table[p] = plfr_pkg::letter_t'(p);
        end
        if (shape == KEY_SHUFFLED || shape == KEY_DUPLICATE)
        begin
            for (int i = plfr_pkg::TABLE_SIZE - 1; i > 0; i--)
            begin
                j               = $urandom_range(0, i);
                t               = staged_table[i];
                staged_table[i] = staged_table[j];
                staged_table[j] = t;
            end
        end
        for (int p = 0; p < plfr_pkg::TABLE_SIZE; p++)
        begin
            case (shape)
                KEY_ALL_ZERO:  staged_table[p] = '0;
                KEY_ALL_ONES:  staged_table[p] = '1;
                KEY_ARBITRARY: staged_table[p] = plfr_pkg::letter_t'($urandom);
                default:       ;
            endcase
        end
        // A copied entry leaves one letter missing and one found twice.
        if (shape == KEY_DUPLICATE)
        begin
            for (int n = 0; n < 3; n++)
            begin
                staged_table[$urandom_range(0, plfr_pkg::TABLE_SIZE - 1)] =
                    staged_table[$urandom_range(0, plfr_pkg::TABLE_SIZE - 1)];
            end
        end
        // Upper bits of the mode word are noise; only bit 0 counts.
        grp = random_word();
        grp[0] = mode;
        write_reg(plfr_pkg::REG_DECRYPT_MODE, grp);
        for (int g = 0; g < plfr_pkg::TABLE_SIZE / plfr_pkg::GROUP_SIZE; g++)
        begin
            grp = '0;
            for (int k = 0; k < plfr_pkg::GROUP_SIZE; k++)
            begin
                grp[plfr_pkg::LETTER_W * k +: plfr_pkg::LETTER_W] =
                    staged_table[plfr_pkg::GROUP_SIZE * g + k];
            end
            write_reg(plfr_pkg::CFG_INDEX_W'(int'(plfr_pkg::REG_TABLE_GROUP_0) + g), grp);
        end
        // Writes past the last register must change nothing.
        if (poke_unused)
        begin
            for (int i = int'(FIRST_UNUSED_REG); i < (1 << plfr_pkg::CFG_INDEX_W); i++)
            begin
                write_reg(plfr_pkg::CFG_INDEX_W'(i), random_word());
            end
        end
        cfg_we <= 1'b0;
    endtask

    // Random text: mostly letters of both cases, doubled letters, spaces,
    // stray bytes and line ends.
    task automatic random_item(output logic [plfr_pkg::CHAR_W-1:0] c, output logic eol);
        int k;
        k = $urandom_range(0, 99);
        if (k < 62)
            c = plfr_pkg::CHAR_W'($urandom_range(int'(UPPER_BASE), 255));
        else if (k < 74)
            c = ($urandom_range(0, 1) ? UPPER_BASE : LOWER_BASE) |
                plfr_pkg::CHAR_W'(last_letter);
        else if (k < 86)
            c = SPACE_CHAR;
        else
            c = plfr_pkg::CHAR_W'($urandom_range(0, 255));
        eol = ($urandom_range(0, 7) == 0);
        if (c[plfr_pkg::CHAR_W-1 -: 2] == plfr_pkg::LETTER_TAG)
            last_letter = c[plfr_pkg::LETTER_W-1:0];
    endtask

    // Directed text on the reset table in encrypt mode.
    task automatic directed_text();
        send_char(8'hC0, 1'b0);  // upper case folded, same row as the next
        send_char(8'hE1, 1'b0);
        send_char(8'hE0, 1'b0);  // same column
        send_char(8'hE4, 1'b0);
        send_char(8'hE0, 1'b0);  // rectangle across the table corners
        send_char(8'hFF, 1'b0);
        send_char(8'hE5, 1'b0);  // doubled letter across cases
        send_char(8'hC5, 1'b0);
        send_char(SPACE_CHAR, 1'b1);  // line end on a space flushes the held letter
        send_char(8'hE7, 1'b0);  // doubled letter at line end gives two pairs
        send_char(8'hE7, 1'b1);
        send_char(8'hEA, 1'b0);  // stray bytes between the letters of a pair
        send_char(8'h00, 1'b0);
        send_char(8'hBF, 1'b0);
        send_char(8'h7F, 1'b0);
        send_char(8'h80, 1'b0);
        send_char(8'hEB, 1'b0);
        send_char(8'hDF, 1'b1);  // lone letter at line end
        send_char(SPACE_CHAR, 1'b1);  // line end with nothing held
        send_char(8'hFA, 1'b0);  // the filler letter doubled
        send_char(8'hFA, 1'b1);
        send_char(8'hFF, 1'b0);
        send_char(8'hDF, 1'b1);
    endtask

    // Stimulus and configuration.
    initial
    begin
        logic [plfr_pkg::CHAR_W-1:0] c;
        logic                        eol;
        int                          sent;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_wdata   = '0;
        in_valid    = 1'b0;
        in_char     = '0;
        end_of_line = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_text();
        drain();

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            case (p)
                0:       load_key(KEY_IDENTITY, 1'b0, 1'b0);
                1:       load_key(KEY_IDENTITY, 1'b1, 1'b0);
                2:       load_key(KEY_SHUFFLED, 1'b0, 1'b0);
                3:       load_key(KEY_SHUFFLED, 1'b1, 1'b0);
                4:       load_key(KEY_ALL_ZERO, 1'($urandom), 1'b0);
                5:       load_key(KEY_ALL_ONES, 1'($urandom), 1'b0);
                6:       load_key(KEY_ARBITRARY, 1'b0, 1'b0);
                7:       load_key(KEY_DUPLICATE, 1'b1, 1'b0);
                8:       load_key(KEY_SHUFFLED, 1'($urandom), 1'b1);
                default: load_key(KEY_ARBITRARY, 1'b1, 1'b0);
            endcase
            // Every third phase runs with no idling on either side.
            idle_on = (p % 3 != 2);
            // The receiver holds off while the sender keeps offering.
            if (p == PRESSURE_PHASE)
                hold_req = 1'b1;
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                random_item(c, eol);
                send_char(c, eol);
                sent++;
            end
            drain();
        end

        if (sb.pending() != 0)
            sb.report($sformatf("%0d pairs never came out", sb.pending()));
        if (sb.mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
